[design/gtc_pkg.sv]
// gtc_pkg: shared constants, state encoding and controller/datapath bundles
// for the graph transitive closure block. No dependencies.

package gtc_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = 4;
    localparam int CNT_W     = 5;
    localparam int ROW_W     = 16;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_EXPAND,
        ST_EMIT_LOAD,
        ST_EMIT_WAIT
    } gtc_state_t;

    typedef struct packed {
        logic load;
        logic clr_src;
        logic start;
        logic step;
        logic expand;
        logic finish;
        logic emit_load;
        logic emit_next;
    } gtc_cmd_t;

    typedef struct packed {
        logic pending_zero;
        logic src_last;
    } gtc_status_t;

endpackage

[design/gtc_if.sv]
// gtc_if: valid/ready channel interfaces for adjacency rows in and closure rows out.
// Depends on gtc_pkg for field widths.

interface gtc_in_if;
    logic                        valid;
    logic                        ready;
    logic [gtc_pkg::NODE_W-1:0]  row_index;
    logic [gtc_pkg::ROW_W-1:0]   adjacency_row;
    logic                        last_row;

    modport source (output valid, row_index, adjacency_row, last_row, input ready);
    modport sink   (input valid, row_index, adjacency_row, last_row, output ready);
endinterface

interface gtc_out_if;
    logic                        valid;
    logic                        ready;
    logic [gtc_pkg::NODE_W-1:0]  closure_index;
    logic [gtc_pkg::ROW_W-1:0]   closure_row;
    logic                        last_result;

    modport source (output valid, closure_index, closure_row, last_result, input ready);
    modport sink   (input valid, closure_index, closure_row, last_result, output ready);
endinterface

[design/gtc_ctrl.sv]
// gtc_ctrl: sequencer for load, per-source walk (lowest pending node first) and row emission.
// Depends on gtc_pkg.

module gtc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  logic                 out_ready,
    input  gtc_pkg::gtc_status_t status,
    output gtc_pkg::gtc_cmd_t    cmd
);

    gtc_pkg::gtc_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gtc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            gtc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.clr_src = 1'b1;
                        state_next  = gtc_pkg::ST_START;
                    end
                end
            end
            gtc_pkg::ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = gtc_pkg::ST_WALK;
            end
            gtc_pkg::ST_WALK:
            begin
                if (!status.pending_zero)
                begin
                    cmd.step   = 1'b1;
                    state_next = gtc_pkg::ST_EXPAND;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    if (status.src_last)
                    begin
                        cmd.clr_src = 1'b1;
                        state_next  = gtc_pkg::ST_EMIT_LOAD;
                    end
                    else
                    begin
                        state_next = gtc_pkg::ST_START;
                    end
                end
            end
            gtc_pkg::ST_EXPAND:
            begin
                cmd.expand = 1'b1;
                state_next = gtc_pkg::ST_WALK;
            end
            gtc_pkg::ST_EMIT_LOAD:
            begin
                cmd.emit_load = 1'b1;
                state_next    = gtc_pkg::ST_EMIT_WAIT;
            end
            gtc_pkg::ST_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    cmd.emit_next = 1'b1;
                    state_next    = status.src_last ? gtc_pkg::ST_IDLE
                                                    : gtc_pkg::ST_EMIT_LOAD;
                end
            end
            default:
            begin
                state_next = gtc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/gtc_datapath.sv]
// gtc_datapath: adjacency and closure stores, visited/pending masks, node-count
// register and output register. Depends on gtc_pkg.

module gtc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gtc_pkg::gtc_cmd_t             cmd,
    output gtc_pkg::gtc_status_t          status,
    input  logic                          cfg_we,
    input  logic [gtc_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic [gtc_pkg::NODE_W-1:0]    row_index,
    input  logic [gtc_pkg::ROW_W-1:0]     adjacency_row,
    output logic                          out_valid,
    output logic [gtc_pkg::NODE_W-1:0]    closure_index,
    output logic [gtc_pkg::ROW_W-1:0]     closure_row,
    output logic                          last_result
);

    logic [gtc_pkg::ROW_W-1:0]  adj_mem     [gtc_pkg::MAX_NODES];
    logic [gtc_pkg::ROW_W-1:0]  closure_mem [gtc_pkg::MAX_NODES];

    logic [gtc_pkg::CNT_W-1:0]  node_count_reg;
    logic [gtc_pkg::NODE_W-1:0] src_reg;
    logic [gtc_pkg::ROW_W-1:0]  visited_reg;
    logic [gtc_pkg::ROW_W-1:0]  pending_reg;
    logic [gtc_pkg::ROW_W-1:0]  adj_q_reg;
    logic                       out_valid_reg;
    logic [gtc_pkg::NODE_W-1:0] out_index_reg;
    logic [gtc_pkg::ROW_W-1:0]  out_row_reg;
    logic                       out_last_reg;

    logic [gtc_pkg::CNT_W-1:0]  n_eff;
    logic [gtc_pkg::ROW_W-1:0]  live;
    logic [gtc_pkg::NODE_W-1:0] node_sel;
    logic [gtc_pkg::ROW_W-1:0]  node_bit;
    logic [gtc_pkg::ROW_W-1:0]  src_bit;
    logic [gtc_pkg::ROW_W-1:0]  new_bits;
    logic                       row_in_range;

    always_comb
    begin
        priority if (node_count_reg == '0)
            n_eff = gtc_pkg::CNT_W'(1);
        else if (node_count_reg > gtc_pkg::CNT_W'(gtc_pkg::MAX_NODES))
            n_eff = gtc_pkg::CNT_W'(gtc_pkg::MAX_NODES);
        else
            n_eff = node_count_reg;
    end

    always_comb
    begin
        for (int k = 0; k < gtc_pkg::ROW_W; k++)
        begin
            live[k] = (gtc_pkg::CNT_W'(k) < n_eff);
        end
    end

    // lowest pending node is popped first
    always_comb
    begin
        node_sel = '0;
        for (int k = gtc_pkg::MAX_NODES - 1; k >= 0; k--)
        begin
            if (pending_reg[k])
            begin
                node_sel = gtc_pkg::NODE_W'(k);
            end
        end
    end

    assign node_bit     = gtc_pkg::ROW_W'(1) << node_sel;
    assign src_bit      = gtc_pkg::ROW_W'(1) << src_reg;
    assign new_bits     = adj_q_reg & live & ~visited_reg;
    assign row_in_range = ({1'b0, row_index} < n_eff);

    assign status.pending_zero = (pending_reg == '0);
    assign status.src_last     = (({1'b0, src_reg} + gtc_pkg::CNT_W'(1)) == n_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= gtc_pkg::NODE_COUNT_RST;
            src_reg        <= '0;
            visited_reg    <= '0;
            pending_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end

            if (cmd.clr_src)
            begin
                src_reg <= '0;
            end
            else if (cmd.finish || cmd.emit_next)
            begin
                src_reg <= src_reg + gtc_pkg::NODE_W'(1);
            end

            if (cmd.start)
            begin
                visited_reg <= src_bit;
                pending_reg <= src_bit;
            end
            else if (cmd.step)
            begin
                pending_reg <= pending_reg & ~node_bit;
            end
            else if (cmd.expand)
            begin
                visited_reg <= visited_reg | new_bits;
                pending_reg <= pending_reg | new_bits;
            end

            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.emit_next)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && row_in_range)
        begin
            adj_mem[row_index] <= adjacency_row;
        end
        if (cmd.step)
        begin
            adj_q_reg <= adj_mem[node_sel];
        end
        if (cmd.finish)
        begin
            closure_mem[src_reg] <= visited_reg;
        end
        if (cmd.emit_load)
        begin
            out_index_reg <= src_reg;
            out_row_reg   <= closure_mem[src_reg];
            out_last_reg  <= status.src_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign closure_index = out_index_reg;
    assign closure_row   = out_row_reg;
    assign last_result   = out_last_reg;

endmodule

[design/graph_transitive_closure.sv]
// Transitive closure of a directed graph of up to 16 nodes. Adjacency rows are
// taken one per cycle; a row with last_row set starts a run. Each source gets a
// walk that pops one pending node at a time, lowest first (a registered read of its
// adjacency row, then the expansion), until none is pending. Once every source
// is walked, the closure rows leave one at a time, each held until the sink is
// ready. No new row is taken during a run.
// Depends on gtc_pkg, gtc_if, gtc_ctrl and gtc_datapath.

module graph_transitive_closure (
    input  logic                        clk,
    input  logic                        rst_n,
    gtc_in_if.sink                      adj_ch,
    gtc_out_if.source                   res_ch,
    input  logic                        cfg_we,
    input  logic [gtc_pkg::CNT_W-1:0]   cfg_wdata
);

    gtc_pkg::gtc_cmd_t    cmd;
    gtc_pkg::gtc_status_t status;

    gtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (adj_ch.valid),
        .in_last   (adj_ch.last_row),
        .in_ready  (adj_ch.ready),
        .out_ready (res_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    gtc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .row_index     (adj_ch.row_index),
        .adjacency_row (adj_ch.adjacency_row),
        .out_valid     (res_ch.valid),
        .closure_index (res_ch.closure_index),
        .closure_row   (res_ch.closure_row),
        .last_result   (res_ch.last_result)
    );

endmodule

[design/gtc_checker.sv]
// gtc_checker: port-level assertions for graph_transitive_closure, bound to the top.
// Depends on gtc_pkg and graph_transitive_closure.

module gtc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [gtc_pkg::NODE_W-1:0]  closure_index,
    input  logic [gtc_pkg::ROW_W-1:0]   closure_row,
    input  logic                        last_result
);

    // input side is closed while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is offered");

    // a source always reaches itself
    a_diag_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> closure_row[closure_index])
        else $error("closure row lacks its own node");

    // run ends after the flagged transfer
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_result) |=> (!out_valid && in_ready))
        else $error("activity after last result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(closure_row)
                                       && $stable(closure_index)))
        else $error("stalled result changed");

    // after any row transfer, no result is offered unless the input stays open
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (in_ready || !out_valid))
        else $error("result offered right after a load");

endmodule

bind graph_transitive_closure gtc_checker u_gtc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (adj_ch.valid),
    .in_ready      (adj_ch.ready),
    .out_valid     (res_ch.valid),
    .out_ready     (res_ch.ready),
    .closure_index (res_ch.closure_index),
    .closure_row   (res_ch.closure_row),
    .last_result   (res_ch.last_result)
);

[dv/graph_transitive_closure_tb.sv]
`timescale 1ns / 1ps
// graph_transitive_closure_tb: self-checking testbench for the transitive closure block.
// Loads adjacency rows, predicts the closure rows of each run and checks every transfer out.
// Depends on gtc_pkg, gtc_if and the graph_transitive_closure RTL.

module graph_transitive_closure_tb;

    localparam int ITEM_TARGET = 280;
    localparam int CALM_FROM   = 235;
    localparam int SETTLE      = 8;
    localparam int DRAIN       = 40;
    localparam int LIMIT       = 1000000;

    localparam logic [gtc_pkg::CNT_W-1:0] NODE_PLAN [8] = '{5'd1, 5'd16, 5'd0, 5'd31,
                                                            5'd2, 5'd17, 5'd9, 5'd4};

    typedef struct {
        logic [gtc_pkg::NODE_W-1:0] row;
        logic [gtc_pkg::ROW_W-1:0]  bits;
        logic                       last;
    } adj_xfer_t;

    typedef struct {
        logic [gtc_pkg::NODE_W-1:0] index;
        logic [gtc_pkg::ROW_W-1:0]  row;
        logic                       last;
    } closure_xfer_t;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       cfg_we     = 1'b0;
    logic [gtc_pkg::CNT_W-1:0]  cfg_wdata  = '0;
    logic                       src_valid  = 1'b0;
    logic [gtc_pkg::NODE_W-1:0] src_row    = '0;
    logic [gtc_pkg::ROW_W-1:0]  src_bits   = '0;
    logic                       src_last   = 1'b0;
    logic                       sink_ready = 1'b0;

    gtc_in_if  adj_ch();
    gtc_out_if res_ch();

    assign adj_ch.valid         = src_valid;
    assign adj_ch.row_index     = src_row;
    assign adj_ch.adjacency_row = src_bits;
    assign adj_ch.last_row      = src_last;
    assign res_ch.ready         = sink_ready;

    graph_transitive_closure uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .adj_ch    (adj_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    adj_xfer_t                  row_queue [$];
    closure_xfer_t              closure_due [$];
    adj_xfer_t                  cur_row;
    logic [gtc_pkg::ROW_W-1:0]  adj_copy [gtc_pkg::MAX_NODES];
    logic [gtc_pkg::CNT_W-1:0]  node_count_reg = gtc_pkg::NODE_COUNT_RST;
    logic [gtc_pkg::ROW_W-1:0]  rows_loaded = '0;
    int                         gen_nodes = gtc_pkg::MAX_NODES;
    int                         items_queued = 0;
    int                         errors = 0;
    int                         cycles = 0;
    int                         src_gap = 0;
    int                         sink_gap = 0;
    bit                         calm = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int active_nodes(logic [gtc_pkg::CNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > gtc_pkg::MAX_NODES)
            return gtc_pkg::MAX_NODES;
        return int'(v);
    endfunction

    function automatic logic [gtc_pkg::ROW_W-1:0] node_span(int n);
        return (n >= gtc_pkg::ROW_W) ? '1 : gtc_pkg::ROW_W'((1 << n) - 1);
    endfunction

    // store an in-range row, and on the last row expand every source to a fixed point
    function automatic void absorb_row(adj_xfer_t x);
        int n;
        logic [gtc_pkg::ROW_W-1:0] span;
        logic [gtc_pkg::ROW_W-1:0] reach;
        logic [gtc_pkg::ROW_W-1:0] prior;
        closure_xfer_t c;
        n = active_nodes(node_count_reg);
        span = node_span(n);
        if (int'(x.row) < n)
            adj_copy[x.row] = x.bits;
        if (x.last)
        begin
            for (int s = 0; s < n; s++)
            begin
                reach = '0;
                reach[s] = 1'b1;
                do
                begin
                    prior = reach;
                    for (int k = 0; k < n; k++)
                        if (prior[k])
                            reach |= adj_copy[k] & span;
                end while (reach != prior);
                c.index = gtc_pkg::NODE_W'(s);
                c.row = reach;
                c.last = (s == n - 1);
                closure_due.push_back(c);
            end
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && adj_ch.ready)
                absorb_row(cur_row);
            if (!src_valid || adj_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    src_valid <= 1'b0;
                end
                else if (row_queue.size() > 0 && !calm && $urandom_range(0, 4) == 0)
                begin
                    src_gap = $urandom_range(0, 2);
                    src_valid <= 1'b0;
                end
                else if (row_queue.size() > 0)
                begin
                    cur_row = row_queue.pop_front();
                    src_valid <= 1'b1;
                    src_row <= cur_row.row;
                    src_bits <= cur_row.bits;
                    src_last <= cur_row.last;
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        closure_xfer_t want;
        if (rst_n)
        begin
            if (res_ch.valid && sink_ready)
            begin
                if (closure_due.size() == 0)
                    report_mismatch($sformatf("unexpected transfer index %0d row %h last %b",
                        res_ch.closure_index, res_ch.closure_row, res_ch.last_result));
                else
                begin
                    want = closure_due.pop_front();
                    if (res_ch.closure_index !== want.index)
                        report_mismatch($sformatf("closure_index %0d, expected %0d",
                            res_ch.closure_index, want.index));
                    if (res_ch.closure_row !== want.row)
                        report_mismatch($sformatf("closure_row %h for node %0d, expected %h",
                            res_ch.closure_row, want.index, want.row));
                    if (res_ch.last_result !== want.last)
                        report_mismatch($sformatf("last_result %b for node %0d, expected %b",
                            res_ch.last_result, want.index, want.last));
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                sink_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                sink_gap = $urandom_range(0, 2);
                sink_ready <= 1'b0;
            end
            else
                sink_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_row(int row, logic [gtc_pkg::ROW_W-1:0] bits, bit last);
        adj_xfer_t x;
        x.row = gtc_pkg::NODE_W'(row);
        x.bits = bits;
        x.last = last;
        row_queue.push_back(x);
        if (row < gen_nodes)
            rows_loaded[row] = 1'b1;
        items_queued++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (row_queue.size() != 0 || src_valid || closure_due.size() != 0);
    endtask

    task automatic set_node_count(logic [gtc_pkg::CNT_W-1:0] v);
        wait_idle();
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        node_count_reg = v;
        gen_nodes = active_nodes(v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly sparse graphs, so walks go several levels deep
    function automatic logic [gtc_pkg::ROW_W-1:0] random_adj(int n);
        logic [gtc_pkg::ROW_W-1:0] b;
        b = '0;
        case ($urandom_range(0, 7))
            0: b = '1;
            1: b = gtc_pkg::ROW_W'($urandom);
            default:
            begin
                repeat ($urandom_range(0, 2))
                    b[$urandom_range(0, n - 1)] = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    b |= gtc_pkg::ROW_W'($urandom) & ~node_span(n);
            end
        endcase
        return b;
    endfunction

    // one graph ending in a last row; rows still unwritten are always loaded before it
    task automatic queue_graph(bit tidy);
        int n;
        int order [gtc_pkg::MAX_NODES];
        int j;
        int t;
        n = gen_nodes;
        if (tidy)
        begin
            for (int k = 0; k < n; k++)
                order[k] = k;
            for (int k = n - 1; k > 0; k--)
            begin
                j = $urandom_range(0, k);
                t = order[k];
                order[k] = order[j];
                order[j] = t;
            end
            for (int k = 0; k < n; k++)
                if (!rows_loaded[order[k]] || $urandom_range(0, 3) != 0)
                    queue_row(order[k], random_adj(n), 1'b0);
            if (n < gtc_pkg::MAX_NODES && $urandom_range(0, 2) == 0)
                queue_row($urandom_range(n, gtc_pkg::MAX_NODES - 1), random_adj(n), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(0, 3))
                queue_row($urandom_range(0, gtc_pkg::MAX_NODES - 1),
                          gtc_pkg::ROW_W'($urandom), 1'b0);
            for (int k = 0; k < n; k++)
                if (!rows_loaded[k])
                    queue_row(k, random_adj(n), 1'b0);
        end
        queue_row($urandom_range(0, gtc_pkg::MAX_NODES - 1), random_adj(n), 1'b1);
    endtask

    initial
    begin
        int phase;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // full 16-node load: empty row, full row, and a chain that ends in the empty node
        queue_row(0, 16'h0000, 1'b0);
        queue_row(1, 16'hFFFF, 1'b0);
        for (int r = 2; r < 15; r++)
            queue_row(r, gtc_pkg::ROW_W'(1) << (r + 1), 1'b0);
        queue_row(15, 16'h0001, 1'b1);

        // zero count acts as one; out-of-range row still starts a run
        set_node_count(5'd0);
        queue_row(5, 16'hFFFF, 1'b1);
        queue_row(0, 16'hFFFE, 1'b1);

        set_node_count(5'd31);
        queue_row(15, 16'h5555, 1'b0);
        queue_row(0, 16'hAAAA, 1'b1);

        set_node_count(5'd2);
        queue_row(1, 16'h0001, 1'b0);
        queue_row(0, 16'h0002, 1'b1);

        phase = 0;
        while (items_queued < ITEM_TARGET)
        begin
            set_node_count(phase < 8 ? NODE_PLAN[phase]
                                     : gtc_pkg::CNT_W'($urandom_range(0, 31)));
            calm = (items_queued >= CALM_FROM);
            repeat ($urandom_range(1, 3))
                if (items_queued < ITEM_TARGET)
                    queue_graph($urandom_range(0, 3) != 0);
            phase++;
        end

        wait_idle();
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
